>>> src/hwpf_pkg.sv
// Shared constants, beat types and match functions for the haplotype window phase flip unit.
package hwpf_pkg;

  localparam int unsigned LOOKBACK      = 4;
  localparam int unsigned MAX_READS     = 128;
  localparam int unsigned IDX_W         = $clog2(MAX_READS);
  localparam int unsigned CODE_W        = 4;
  localparam int unsigned HIST_W        = CODE_W * LOOKBACK;
  localparam int unsigned CNT_W         = 9;
  localparam int unsigned POS_W         = 3;

  localparam logic [CODE_W-1:0] CODE_PADDING  = 4'd0;
  localparam logic [CODE_W-1:0] CODE_DELETION = 4'd5;
  localparam logic [CNT_W-1:0]  COUNT_MAX     = '1;

  typedef struct packed {
    logic              new_region;
    logic [IDX_W-1:0]  read_index;
    logic [CODE_W-1:0] basecall;
    logic [CODE_W-1:0] hap0_class;
    logic [CODE_W-1:0] hap1_class;
    logic              last_read;
  } in_t;

  typedef struct packed {
    logic             swap;
    logic             decided;
    logic [CNT_W-1:0] keep_support;
    logic [CNT_W-1:0] cross_support;
  } out_t;

  // Item held in the compare stage, waiting on the history read.
  typedef struct packed {
    logic vld;
    in_t  item;
  } stage_t;

  function automatic logic call_matches(logic [CODE_W-1:0] raw, logic [CODE_W-1:0] cls);
    logic m;
    if (raw == CODE_PADDING) begin
      m = 1'b0;
    end else if (raw == CODE_DELETION) begin
      m = (cls == '0);
    end else begin
      m = (raw == cls);
    end
    return m;
  endfunction

  function automatic logic hist_matches(logic [HIST_W-1:0] calls, logic [HIST_W-1:0] classes);
    logic m;
    m = 1'b1;
    for (int unsigned k = 0; k < LOOKBACK; k++) begin
      m &= call_matches(calls[k*CODE_W +: CODE_W], classes[k*CODE_W +: CODE_W]);
    end
    return m;
  endfunction

endpackage

>>> src/haplotype_window_phase_flip_unit.sv
// Top level of the haplotype window phase flip unit.
// Takes one read basecall beat per cycle while the input is not stalled. A beat reads
// its read's history from a 128-entry memory when it is accepted and waits in the
// compare stage register; it is compared and written back when it leaves that stage,
// and a last-read beat places its result in the output register at that same edge. A
// back-to-back beat of the same read takes the written-back history from a bypass
// register. The input stalls only while a last-read beat waits for a result still held downstream.
module haplotype_window_phase_flip_unit
  import hwpf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic              s1_vld_q;
  in_t               s1_item_q;
  stage_t            s1;
  logic              fire, in_acc;
  logic [HIST_W-1:0] rd_data, read_hist, new_hist;
  logic              byp_vld_q;
  logic [IDX_W-1:0]  byp_addr_q;
  logic [HIST_W-1:0] byp_data_q;

  assign s1         = '{vld: s1_vld_q, item: s1_item_q};
  assign in_stall_o = s1_vld_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      byp_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (fire) begin
        s1_vld_q <= 1'b0;
      end
      if (fire) begin
        byp_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_i;
    end
    if (fire) begin
      byp_addr_q <= s1_item_q.read_index;
      byp_data_q <= new_hist;
    end
  end

  // Take the history written at the read edge from the bypass.
  assign read_hist = (byp_vld_q && byp_addr_q == s1_item_q.read_index) ? byp_data_q : rd_data;
  assign new_hist  = HIST_W'({read_hist, s1_item_q.basecall});

  hwpf_hist_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_i.read_index),
    .wr_en_i   (fire),
    .wr_addr_i (s1_item_q.read_index),
    .wr_data_i (new_hist),
    .rd_data_o (rd_data)
  );

  hwpf_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (s1),
    .read_hist_i (read_hist),
    .fire_o      (fire),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> src/hwpf_hist_ram.sv
// Per-read basecall history memory: one write port, one registered read port.
module hwpf_hist_ram
  import hwpf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  logic [HIST_W-1:0] wr_data_i,
  output logic [HIST_W-1:0] rd_data_o
);

  logic [HIST_W-1:0] mem_q [MAX_READS];
  logic [HIST_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/hwpf_decide.sv
// Window match counting, haplotype history, swap decision and the result register.
module hwpf_decide
  import hwpf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stage_t            stage_i,
  input  logic [HIST_W-1:0] read_hist_i,
  output logic              fire_o,
  output logic              out_valid_o,
  output out_t              out_o,
  input  logic              out_stall_i
);

  logic [2*HIST_W-1:0] hap_q;
  logic [CNT_W-1:0]    unflip_q, flip_q;
  logic [POS_W-1:0]    pos_q;
  logic                out_vld_q;
  out_t                out_q;

  in_t                 item;
  logic [CNT_W-1:0]    base_u, base_f, sum_u, sum_f;
  logic [CNT_W:0]      raw_u, raw_f;
  logic [POS_W-1:0]    pos_base;
  logic [HIST_W-1:0]   h0, h1;
  logic                m0, m1, b0, b1;
  logic [1:0]          add_u, add_f;
  logic                full, swap, out_free;
  logic [CODE_W-1:0]   n0, n1;

  always_comb begin
    item     = stage_i.item;
    h0       = hap_q[HIST_W-1:0];
    h1       = hap_q[2*HIST_W-1:HIST_W];
    // A new region clears the window before the beat counts.
    base_u   = item.new_region ? '0 : unflip_q;
    base_f   = item.new_region ? '0 : flip_q;
    pos_base = item.new_region ? '0 : pos_q;
    m0       = hist_matches(read_hist_i, h0);
    m1       = hist_matches(read_hist_i, h1);
    b0       = call_matches(item.basecall, item.hap0_class);
    b1       = call_matches(item.basecall, item.hap1_class);
    add_u    = 2'({1'b0, m0 & b0}) + 2'({1'b0, m1 & b1});
    add_f    = 2'({1'b0, m0 & b1}) + 2'({1'b0, m1 & b0});
    raw_u    = {1'b0, base_u} + (CNT_W+1)'(add_u);
    raw_f    = {1'b0, base_f} + (CNT_W+1)'(add_f);
    sum_u    = raw_u[CNT_W] ? COUNT_MAX : raw_u[CNT_W-1:0];
    sum_f    = raw_f[CNT_W] ? COUNT_MAX : raw_f[CNT_W-1:0];
    full     = (pos_base >= POS_W'(LOOKBACK));
    swap     = full && (sum_f > sum_u);
    n0       = swap ? item.hap1_class : item.hap0_class;
    n1       = swap ? item.hap0_class : item.hap1_class;
    out_free = !out_vld_q || !out_stall_i;
    fire_o   = stage_i.vld && (!item.last_read || out_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hap_q     <= '0;
      unflip_q  <= '0;
      flip_q    <= '0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire_o && item.last_read) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (fire_o) begin
        if (item.last_read) begin
          hap_q     <= {HIST_W'({h1, n1}), HIST_W'({h0, n0})};
          pos_q     <= full ? pos_base : pos_base + 1'b1;
          unflip_q  <= '0;
          flip_q    <= '0;
        end else begin
          pos_q    <= pos_base;
          unflip_q <= sum_u;
          flip_q   <= sum_f;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_o && item.last_read) begin
      out_q.swap          <= swap;
      out_q.decided       <= full;
      out_q.keep_support  <= full ? sum_u : '0;
      out_q.cross_support <= full ? sum_f : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule
